// File: hdl/sms_pkg.sv
// Shared types, codes and constants of the sorted matrix staircase search unit.
package sms_pkg;

   localparam int DATA_W       = 32;
   localparam int IDX_W        = 4;
   localparam int CFG_W        = 5;
   localparam int CSR_IDX_W    = 1;
   localparam int MAX_ROWS_DEF = 16;
   localparam int MAX_COLS_DEF = 16;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 1'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_HOLD
   } walk_state_type;

   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_type;

endpackage

// File: hdl/sms_cmp.sv
// Signed two's complement comparator shared by every step of the walk.
module sms_cmp (
   input  logic signed [sms_pkg::DATA_W-1:0] elem,
   input  logic signed [sms_pkg::DATA_W-1:0] key,
   output sms_pkg::cmp_type                  result
);

   always_comb begin
      result.eq = (elem == key);
      result.lt = (elem < key);
   end

endmodule

// File: hdl/sms_store.sv
// Matrix element memory with one write port and one registered read port.
module sms_store #(
   parameter int DEPTH  = sms_pkg::MAX_ROWS_DEF * sms_pkg::MAX_COLS_DEF,
   parameter int ADDR_W = $clog2(sms_pkg::MAX_ROWS_DEF * sms_pkg::MAX_COLS_DEF)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [sms_pkg::DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [sms_pkg::DATA_W-1:0] rd_data
);

   logic [sms_pkg::DATA_W-1:0] mem [DEPTH];
   logic [sms_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sms_walk.sv
// Sequencer that walks the matrix one element per cycle and holds the result beat.
module sms_walk #(
   parameter int MAX_ROWS = sms_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = sms_pkg::MAX_COLS_DEF,
   parameter int ROW_W    = $clog2(sms_pkg::MAX_ROWS_DEF + 1),
   parameter int COL_W    = $clog2(sms_pkg::MAX_COLS_DEF + 1),
   parameter int ADDR_W   = $clog2(sms_pkg::MAX_ROWS_DEF * sms_pkg::MAX_COLS_DEF)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ROW_W-1:0]            rows,
   input  logic [COL_W-1:0]            cols,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  logic [sms_pkg::IDX_W-1:0]   req_row_index,
   input  logic [sms_pkg::IDX_W-1:0]   req_col_index,
   input  logic [sms_pkg::DATA_W-1:0]  req_data_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [sms_pkg::IDX_W-1:0]   rsp_found_row,
   output logic [sms_pkg::IDX_W-1:0]   rsp_found_col,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [sms_pkg::DATA_W-1:0]  wr_data,
   output logic [ADDR_W-1:0]           rd_addr,
   input  logic [sms_pkg::DATA_W-1:0]  rd_data
);

   sms_pkg::walk_state_type state_ff, state_in;

   // The row counter sits one above the current row, so the walk leaves the top at one.
   logic [ROW_W-1:0]                row_ff, row_in;
   logic [COL_W-1:0]                col_ff, col_in;
   logic [ADDR_W-1:0]               addr_ff, addr_in;
   logic signed [sms_pkg::DATA_W-1:0] key_ff, key_in;
   logic                            pend_found_ff, pend_found_in;
   logic [sms_pkg::IDX_W-1:0]       pend_row_ff, pend_row_in;
   logic [sms_pkg::IDX_W-1:0]       pend_col_ff, pend_col_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff;
   logic [sms_pkg::IDX_W-1:0]       rsp_row_ff;
   logic [sms_pkg::IDX_W-1:0]       rsp_col_ff;

   logic                            accept;
   logic                            rsp_load;
   logic                            rsp_free;
   logic                            in_range;
   logic                            last_col;
   logic [ADDR_W-1:0]               start_addr;
   sms_pkg::cmp_type                cmp;

   sms_cmp u_cmp (
      .elem   (rd_data),
      .key    (key_ff),
      .result (cmp)
   );

   assign accept     = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign in_range   = (32'(req_row_index) < MAX_ROWS) && (32'(req_col_index) < MAX_COLS);
   assign start_addr = ADDR_W'((32'(rows) - 32'd1) * MAX_COLS);
   assign last_col   = ((COL_W + 1)'(col_ff) + (COL_W + 1)'(1)) == (COL_W + 1)'(cols);

   assign wr_addr = ADDR_W'(32'(req_row_index) * MAX_COLS + 32'(req_col_index));
   assign wr_data = req_data_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      addr_ff       <= addr_in;
      key_ff        <= key_in;
      pend_found_ff <= pend_found_in;
      pend_row_ff   <= pend_row_in;
      pend_col_ff   <= pend_col_in;
   end

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      addr_in       = addr_ff;
      key_in        = key_ff;
      pend_found_in = pend_found_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      req_stall     = reset || (state_ff != sms_pkg::ST_IDLE);
      wr_en         = 1'b0;
      rsp_load      = 1'b0;
      rd_addr       = addr_ff;

      unique case (state_ff)
         sms_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_kind == sms_pkg::KIND_LOAD) begin
                  wr_en = in_range;
               end else begin
                  key_in        = req_data_value;
                  pend_found_in = 1'b0;
                  pend_row_in   = '0;
                  pend_col_in   = '0;
                  if (rows == '0 || cols == '0) begin
                     state_in = sms_pkg::ST_HOLD;
                  end else begin
                     row_in   = rows;
                     col_in   = '0;
                     addr_in  = start_addr;
                     rd_addr  = start_addr;
                     state_in = sms_pkg::ST_STEP;
                  end
               end
            end
         end

         sms_pkg::ST_STEP: begin
            if (cmp.eq) begin
               pend_found_in = 1'b1;
               pend_row_in   = sms_pkg::IDX_W'(row_ff - ROW_W'(1));
               pend_col_in   = sms_pkg::IDX_W'(col_ff);
               state_in      = sms_pkg::ST_HOLD;
            end else if (cmp.lt) begin
               if (last_col) begin
                  state_in = sms_pkg::ST_HOLD;
               end else begin
                  col_in  = col_ff + COL_W'(1);
                  addr_in = addr_ff + ADDR_W'(1);
               end
            end else begin
               if (row_ff == ROW_W'(1)) begin
                  state_in = sms_pkg::ST_HOLD;
               end else begin
                  row_in  = row_ff - ROW_W'(1);
                  addr_in = addr_ff - ADDR_W'(MAX_COLS);
               end
            end
            rd_addr = addr_in;
         end

         sms_pkg::ST_HOLD: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = sms_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sms_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= pend_found_ff;
         rsp_row_ff   <= pend_row_ff;
         rsp_col_ff   <= pend_col_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_found_row = rsp_row_ff;
   assign rsp_found_col = rsp_col_ff;

endmodule

// File: hdl/sorted_matrix_staircase_search_unit.sv
// Sorted matrix staircase search: size registers, element store and walk sequencer.
// A load beat gives no result and leaves the sequencer idle; the next beat is taken in the next cycle.
// A search beat walks one element per cycle through the shared comparator and store read
// port, at most rows + cols - 1 steps, and then waits in the hold state until the output
// register is free; an empty size skips the walk and goes straight to the hold state.
// Synchronous reset clears the sequencer, the result valid and the size registers (16 by
// 16); the element store is not cleared and must be written before it is searched.
module sorted_matrix_staircase_search_unit #(
   parameter int MAX_ROWS = sms_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = sms_pkg::MAX_COLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sms_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [sms_pkg::IDX_W-1:0]     req_row_index,
   input  logic [sms_pkg::IDX_W-1:0]     req_col_index,
   input  logic signed [sms_pkg::DATA_W-1:0] req_data_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [sms_pkg::IDX_W-1:0]     rsp_found_row,
   output logic [sms_pkg::IDX_W-1:0]     rsp_found_col
);

   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int COL_W  = $clog2(MAX_COLS + 1);
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [sms_pkg::CFG_W-1:0]  num_rows_ff, num_rows_in;
   logic [sms_pkg::CFG_W-1:0]  num_cols_ff, num_cols_in;
   logic [ROW_W-1:0]           rows;
   logic [COL_W-1:0]           cols;

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [sms_pkg::DATA_W-1:0] wr_data;
   logic [ADDR_W-1:0]          rd_addr;
   logic [sms_pkg::DATA_W-1:0] rd_data;

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            sms_pkg::CSR_NUM_ROWS: num_rows_in = csr_wdata;
            sms_pkg::CSR_NUM_COLS: num_cols_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= sms_pkg::CFG_W'(16);
         num_cols_ff <= sms_pkg::CFG_W'(16);
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
      end
   end

   // Sizes above the store saturate to the store's extent.
   assign rows = (32'(num_rows_ff) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(num_rows_ff);
   assign cols = (32'(num_cols_ff) > MAX_COLS) ? COL_W'(MAX_COLS) : COL_W'(num_cols_ff);

   sms_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sms_walk #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .ROW_W    (ROW_W),
      .COL_W    (COL_W),
      .ADDR_W   (ADDR_W)
   ) u_walk (
      .clock          (clock),
      .reset          (reset),
      .rows           (rows),
      .cols           (cols),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_data_value (req_data_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_found_row  (rsp_found_row),
      .rsp_found_col  (rsp_found_col),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

endmodule

// File: verif/tb_sorted_matrix_staircase_search_unit.sv
// Self-checking testbench for the sorted matrix staircase search unit.
module tb_sorted_matrix_staircase_search_unit;

   localparam int ROWS           = sms_pkg::MAX_ROWS_DEF;
   localparam int COLS           = sms_pkg::MAX_COLS_DEF;
   localparam int CLK_PERIOD     = 12;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_OFF       = 300;
   localparam int RANDOM_BEATS   = 450;
   localparam int TIMEOUT_CYCLES = 800000;

   typedef struct packed {
      logic                      found;
      logic [sms_pkg::IDX_W-1:0] row;
      logic [sms_pkg::IDX_W-1:0] col;
   } hit_type;

   class search_scoreboard;
      logic signed [sms_pkg::DATA_W-1:0] cells [ROWS][COLS];
      logic [sms_pkg::CFG_W-1:0]         num_rows;
      logic [sms_pkg::CFG_W-1:0]         num_cols;
      hit_type                           due [$];
      int                                errors;

      function new();
         num_rows = sms_pkg::CFG_W'(ROWS);
         num_cols = sms_pkg::CFG_W'(COLS);
         errors   = 0;
      endfunction

      function void write_reg(logic [sms_pkg::CSR_IDX_W-1:0] index,
                              logic [sms_pkg::CFG_W-1:0] value);
         case (index)
            sms_pkg::CSR_NUM_ROWS: num_rows = value;
            sms_pkg::CSR_NUM_COLS: num_cols = value;
            default: ;
         endcase
      endfunction

      // Walk from the bottom-left corner: right on a smaller element, up on a larger one.
      function hit_type walk(logic signed [sms_pkg::DATA_W-1:0] key);
         hit_type hit;
         int      r;
         int      c;
         int      col_lim;
         hit     = '0;
         r       = (num_rows > ROWS) ? ROWS : int'(num_rows);
         col_lim = (num_cols > COLS) ? COLS : int'(num_cols);
         c       = 0;
         while (r > 0 && c < col_lim) begin
            if (cells[sms_pkg::IDX_W'(r - 1)][sms_pkg::IDX_W'(c)] == key) begin
               hit.found = 1'b1;
               hit.row   = sms_pkg::IDX_W'(r - 1);
               hit.col   = sms_pkg::IDX_W'(c);
               break;
            end else if (cells[sms_pkg::IDX_W'(r - 1)][sms_pkg::IDX_W'(c)] < key) begin
               c++;
            end else begin
               r--;
            end
         end
         return hit;
      endfunction

      function void note_beat(logic kind, logic [sms_pkg::IDX_W-1:0] row,
                              logic [sms_pkg::IDX_W-1:0] col,
                              logic signed [sms_pkg::DATA_W-1:0] value);
         if (kind == sms_pkg::KIND_LOAD) begin
            cells[row][col] = value;
         end else begin
            due.push_back(walk(value));
         end
      endfunction

      function void check_hit(logic found, logic [sms_pkg::IDX_W-1:0] row,
                              logic [sms_pkg::IDX_W-1:0] col);
         hit_type want;
         if (due.size() == 0) begin
            $error("result beat arrived with no search outstanding");
            errors++;
            return;
         end
         want = due.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            errors++;
         end
         if (row !== want.row) begin
            $error("found_row: expected %0d, got %0d", want.row, row);
            errors++;
         end
         if (col !== want.col) begin
            $error("found_col: expected %0d, got %0d", want.col, col);
            errors++;
         end
      endfunction
   endclass

   logic                              clock          = 1'b0;
   logic                              reset          = 1'b1;
   logic                              csr_wr_en      = 1'b0;
   logic [sms_pkg::CSR_IDX_W-1:0]     csr_index      = sms_pkg::CSR_NUM_ROWS;
   logic [sms_pkg::CFG_W-1:0]         csr_wdata      = '0;
   logic                              req_valid      = 1'b0;
   logic                              req_stall;
   logic                              req_kind       = sms_pkg::KIND_LOAD;
   logic [sms_pkg::IDX_W-1:0]         req_row_index  = '0;
   logic [sms_pkg::IDX_W-1:0]         req_col_index  = '0;
   logic signed [sms_pkg::DATA_W-1:0] req_data_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall      = 1'b0;
   logic                              rsp_found;
   logic [sms_pkg::IDX_W-1:0]         rsp_found_row;
   logic [sms_pkg::IDX_W-1:0]         rsp_found_col;

   search_scoreboard                  sb = new();
   logic signed [sms_pkg::DATA_W-1:0] grid [ROWS][COLS];
   int                                beats_taken   = 0;
   int                                stall_left    = 0;
   bit                                req_idle_on   = 1'b0;
   bit                                rsp_idle_on   = 1'b0;
   bit                                hold_off_req  = 1'b0;

   sorted_matrix_staircase_search_unit u_top (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [sms_pkg::CFG_W-1:0] pick_size();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return '0;
      if (pick < 10) return sms_pkg::CFG_W'($urandom_range(ROWS + 1, 31));
      if (pick < 30) return sms_pkg::CFG_W'($urandom_range(5, ROWS));
      return sms_pkg::CFG_W'($urandom_range(1, 4));
   endfunction

   function automatic int clip(logic [sms_pkg::CFG_W-1:0] n, int lim);
      return (n > lim) ? lim : int'(n);
   endfunction

   function automatic logic [sms_pkg::IDX_W-1:0] pick_idx(int hi);
      return sms_pkg::IDX_W'($urandom_range(0, hi));
   endfunction

   // Result side: check accepted beats and stall at random or for the long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_hit(rsp_found, rsp_found_row, rsp_found_col);
      if (stall_left == 0) begin
         if (hold_off_req) begin
            stall_left   = HOLD_OFF;
            hold_off_req = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = idle_len();
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic rest(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_beat(logic kind, logic [sms_pkg::IDX_W-1:0] row,
                            logic [sms_pkg::IDX_W-1:0] col,
                            logic signed [sms_pkg::DATA_W-1:0] value);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_row_index  <= row;
      req_col_index  <= col;
      req_data_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_beat(kind, row, col, value);
      beats_taken++;
      if (req_idle_on) rest(idle_len());
   endtask

   // A load gives no result, so only searches are waited for before the settle time.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_size(logic [sms_pkg::CFG_W-1:0] rows, logic [sms_pkg::CFG_W-1:0] cols);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= sms_pkg::CSR_NUM_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= sms_pkg::CSR_NUM_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(sms_pkg::CSR_NUM_ROWS, rows);
      sb.write_reg(sms_pkg::CSR_NUM_COLS, cols);
   endtask

   // Each element after the first is its upper and left neighbors' maximum plus a random step, clamped.
   task automatic load_staircase(int nr, int nc, bit pin_ends);
      longint                    v;
      longint                    top;
      int unsigned               step;
      logic [sms_pkg::IDX_W-1:0] ri;
      logic [sms_pkg::IDX_W-1:0] ci;
      case ($urandom_range(0, 3))
         0: step = 2;
         1: step = 1000;
         2: step = 1 << 20;
         default: step = 1 << 27;
      endcase
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            ri = sms_pkg::IDX_W'(r);
            ci = sms_pkg::IDX_W'(c);
            if (r == 0 && c == 0) begin
               v = pin_ends ? -64'sd2147483648 : longint'($signed($urandom()));
            end else begin
               if (r == 0) top = longint'(grid[ri][ci - 1'b1]);
               else if (c == 0) top = longint'(grid[ri - 1'b1][ci]);
               else if (grid[ri - 1'b1][ci] > grid[ri][ci - 1'b1])
                  top = longint'(grid[ri - 1'b1][ci]);
               else top = longint'(grid[ri][ci - 1'b1]);
               v = top + longint'($urandom_range(0, step));
            end
            if (v > 64'sd2147483647 || (pin_ends && r == nr - 1 && c == nc - 1))
               v = 64'sd2147483647;
            grid[ri][ci] = v[sms_pkg::DATA_W-1:0];
            send_beat(sms_pkg::KIND_LOAD, ri, ci, grid[ri][ci]);
         end
      end
   endtask

   initial begin
      logic signed [sms_pkg::DATA_W-1:0] key;
      logic [sms_pkg::CFG_W-1:0]         nr;
      logic [sms_pkg::CFG_W-1:0]         nc;
      int                                er;
      int                                ec;
      int                                start;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Every entry is written before the first search reads anything.
      load_staircase(ROWS, COLS, 1'b1);

      // The receiver holds off while searches keep coming, so the input backs up.
      hold_off_req = 1'b1;
      send_beat(sms_pkg::KIND_SEARCH, 4'd0, 4'd0, grid[ROWS-1][0]);
      send_beat(sms_pkg::KIND_SEARCH, 4'd15, 4'd15, grid[0][COLS-1]);
      send_beat(sms_pkg::KIND_SEARCH, 4'd15, 4'd0, -32'sd2147483648);
      send_beat(sms_pkg::KIND_SEARCH, 4'd0, 4'd15, 32'sd2147483647);
      send_beat(sms_pkg::KIND_SEARCH, 4'd7, 4'd8, grid[7][8]);
      send_beat(sms_pkg::KIND_SEARCH, 4'd3, 4'd12, grid[3][12] + 1);

      // An element that breaks the sort order.
      key = $urandom();
      send_beat(sms_pkg::KIND_LOAD, 4'd8, 4'd8, key);
      send_beat(sms_pkg::KIND_SEARCH, 4'd5, 4'd10, key);

      // A write outside the active area is kept; oversize settings saturate.
      set_size(5'd2, 5'd3);
      key = $urandom();
      send_beat(sms_pkg::KIND_LOAD, 4'd15, 4'd0, key);
      set_size(5'd31, 5'd31);
      send_beat(sms_pkg::KIND_SEARCH, 4'd10, 4'd5, key);
      send_beat(sms_pkg::KIND_SEARCH, 4'd0, 4'd0, sb.cells[0][COLS-1]);

      // Empty matrices never find anything; a 1 by 1 and the full size follow.
      set_size(5'd0, 5'd16);
      send_beat(sms_pkg::KIND_SEARCH, 4'd0, 4'd0, sb.cells[ROWS-1][0]);
      set_size(5'd16, 5'd0);
      send_beat(sms_pkg::KIND_SEARCH, 4'd0, 4'd0, sb.cells[ROWS-1][0]);
      set_size(5'd1, 5'd1);
      send_beat(sms_pkg::KIND_SEARCH, 4'd9, 4'd6, sb.cells[0][0]);
      send_beat(sms_pkg::KIND_SEARCH, 4'd9, 4'd6, sb.cells[0][0] + 1);
      set_size(5'd16, 5'd16);
      send_beat(sms_pkg::KIND_SEARCH, 4'd0, 4'd0, sb.cells[ROWS-1][COLS-1]);

      // Random phases: a fresh sorted active area, then searches with some stray writes.
      start = beats_taken;
      while (beats_taken - start < RANDOM_BEATS) begin
         nr = pick_size();
         nc = pick_size();
         er = clip(nr, ROWS);
         ec = clip(nc, COLS);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         set_size(nr, nc);
         if (er > 0 && ec > 0) load_staircase(er, ec, $urandom_range(0, 7) == 0);
         repeat ($urandom_range(4, 16)) begin
            if ($urandom_range(0, 9) == 0) begin
               send_beat(sms_pkg::KIND_LOAD, pick_idx(15), pick_idx(15), $urandom());
            end else begin
               key = $urandom();
               if (er > 0 && ec > 0) begin
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3, 4, 5:
                        key = sb.cells[pick_idx(er - 1)][pick_idx(ec - 1)];
                     6: key = sb.cells[pick_idx(er - 1)][pick_idx(ec - 1)]
                              + ($urandom_range(0, 1) ? 1 : -1);
                     7: key = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
                     default: ;
                  endcase
               end
               send_beat(sms_pkg::KIND_SEARCH, pick_idx(15), pick_idx(15), key);
            end
         end
      end

      drain();
      if (sb.errors == 0 && sb.due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/sms_pkg.sv
hdl/sms_cmp.sv
hdl/sms_store.sv
hdl/sms_walk.sv
hdl/sorted_matrix_staircase_search_unit.sv
verif/tb_sorted_matrix_staircase_search_unit.sv
